@@ src/mcsc_pkg.sv @@
// mcsc_pkg: widths, codes, stage types and constant tables for the charge shift correction
// drift coefficient and delay factor tables are built at elaboration from their decimal values
// no dependencies
`default_nettype none

package mcsc_pkg;

	// stream widths
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 4;
	localparam int M_TDATA_W = 24;

	// field widths
	localparam int CHARGE_W = 17;
	localparam int TD_W     = 16;
	localparam int SHIFT_W  = 20;

	// channel and range codes
	localparam logic [1:0] CH_ZERO    = 2'd0;
	localparam logic [1:0] CH_ONE     = 2'd1;
	localparam logic [1:0] CH_TWO     = 2'd2;
	localparam logic [1:0] CH_NONE    = 2'd3;
	localparam logic [1:0] RANGE_NONE = 2'd3;

	// coefficient table geometry, index = main * 6 + neighbour * 3 + range
	localparam int RANGE_COUNT = 3;
	localparam int NBR_COUNT   = 2;
	localparam int COEF_COUNT  = 3 * NBR_COUNT * RANGE_COUNT;
	localparam int COEF_IDX_W  = $clog2(COEF_COUNT);
	localparam int COEF_A_W    = 22;
	localparam int COEF_B_W    = 17;

	// delay bin computation
	localparam int FACT_W      = 14;
	localparam int BIN_COUNT   = 151;
	localparam int BIN_W       = $clog2(BIN_COUNT);
	localparam int NUM_W       = TD_W + 1;
	localparam int NUM_OFS     = 10050;
	localparam int BIN_DIV     = 100;
	localparam int NUM_C_W     = $clog2(BIN_COUNT * BIN_DIV);
	localparam int RECIP_SHIFT = 19;
	localparam int RECIP       = (2 ** RECIP_SHIFT + BIN_DIV - 1) / BIN_DIV;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int BINQ_W      = NUM_C_W + RECIP_W;

	localparam logic signed [NUM_W-1:0] NUM_OFFSET = NUM_W'(NUM_OFS);
	localparam logic signed [NUM_W-1:0] NUM_LOW    = -NUM_W'(BIN_DIV);
	localparam logic signed [NUM_W-1:0] NUM_HIGH   = NUM_W'(BIN_COUNT * BIN_DIV);

	// datapath widths
	localparam int BC_W       = COEF_B_W + CHARGE_W;
	localparam int DRIFT_W    = BC_W + 1;
	localparam int PROD_W     = DRIFT_W + FACT_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int FRAC_SHIFT = 28;
	localparam int QUO_W      = SUM_W - FRAC_SHIFT;

	localparam logic [SUM_W-1:0] TRUNC_BIAS = SUM_W'((64'sd1 <<< FRAC_SHIFT) - 64'sd1);
	localparam logic signed [SHIFT_W-1:0] OUT_MAX = {1'b0, {(SHIFT_W - 1){1'b1}}};
	localparam logic signed [SHIFT_W-1:0] OUT_MIN = {1'b1, {(SHIFT_W - 1){1'b0}}};

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	typedef struct packed {
		logic                       en;
		logic                       bin_ok;
		logic [BIN_W-1:0]           bin;
		logic signed [COEF_A_W-1:0] a;
		logic signed [COEF_B_W-1:0] b;
	} nbr_t;

	typedef logic signed [COEF_A_W-1:0] coef_a_tab_t [COEF_COUNT];
	typedef logic signed [COEF_B_W-1:0] coef_b_tab_t [COEF_COUNT];
	typedef logic signed [FACT_W-1:0]   fact_tab_t [BIN_COUNT];

	// intercepts and slopes in millionths
	localparam int A_MICRO [COEF_COUNT] = '{
		-1028149, -1228558, -1365610,  -520255,  -529847,  -857225,
		 -694556, -1062618, -1082860,  -693964,  -975210,  -984536,
		 -421748,  -437119,  -527408,  -623511,  -801759, -1006715
	};
	localparam int B_MICRO [COEF_COUNT] = '{
		16115,  2001,    50, 35423,  3546,   811,
		  163,   406,  -254,  -140,   270,  -162,
		 8884,   717,   -15, -8981,  -870,  -294
	};

	// delay factors in thousandths
	localparam int F_MILLI [BIN_COUNT] = '{
		-1, -1, -2, -2, -3, -4, -5, -7, -9, -12,
		-15, -19, -23, -29, -36, -45, -55, -67, -81, -98,
		-118, -140, -166, -196, -230, -268, -310, -357, -409, -465,
		-526, -592, -662, -737, -814, -895, -978, -1063, -1148, -1232,
		-1315, -1395, -1471, -1542, -1606, -1662, -1710, -1748, -1775, -1790,
		-1793, -1784, -1762, -1727, -1680, -1620, -1549, -1467, -1375, -1274,
		-1165, -1049, -929, -804, -677, -548, -419, -291, -165, -42,
		78, 192, 302, 405, 503, 594, 678, 755, 826, 889,
		946, 997, 1041, 1078, 1110, 1135, 1155, 1170, 1180, 1185,
		1185, 1182, 1174, 1162, 1148, 1129, 1108, 1085, 1058, 1030,
		1000, 968, 935, 900, 865, 829, 792, 755, 718, 682,
		645, 609, 573, 538, 504, 471, 440, 409, 379, 351,
		324, 298, 274, 251, 229, 209, 190, 173, 156, 141,
		127, 114, 102, 91, 81, 72, 64, 57, 50, 44,
		39, 34, 30, 26, 23, 20, 17, 15, 13, 11,
		9
	};

	// round half away from zero of m * 2^20 / 10^6
	function automatic longint coef_q(longint m);
		return (m * 64'sd1048576 + ((m < 0) ? -64'sd500000 : 64'sd500000)) / 64'sd1000000;
	endfunction

	// round half away from zero of m * 2^12 / 10^3
	function automatic longint fact_q(longint m);
		return (m * 64'sd4096 + ((m < 0) ? -64'sd500 : 64'sd500)) / 64'sd1000;
	endfunction

	function automatic coef_a_tab_t build_coef_a();
		coef_a_tab_t t;
		for (int i = 0; i < COEF_COUNT; i++) begin
			t[i] = COEF_A_W'(coef_q(longint'(A_MICRO[i])));
		end
		return t;
	endfunction

	function automatic coef_b_tab_t build_coef_b();
		coef_b_tab_t t;
		for (int i = 0; i < COEF_COUNT; i++) begin
			t[i] = COEF_B_W'(coef_q(longint'(B_MICRO[i])));
		end
		return t;
	endfunction

	function automatic fact_tab_t build_fact();
		fact_tab_t t;
		for (int i = 0; i < BIN_COUNT; i++) begin
			t[i] = FACT_W'(fact_q(longint'(F_MILLI[i])));
		end
		return t;
	endfunction

	localparam coef_a_tab_t COEF_A = build_coef_a();
	localparam coef_b_tab_t COEF_B = build_coef_b();
	localparam fact_tab_t   FACT   = build_fact();

endpackage

`default_nettype wire

@@ src/mcsc_front.sv @@
// mcsc_front: stage 1, picks the two neighbour channels, looks up their drift coefficients
// and computes the delay bin of each; uses mcsc_pkg
`default_nettype none

module mcsc_front (
	input  wire                                 clk,
	input  mcsc_pkg::stage_en_t                 en,
	input  wire  [1:0]                          main_channel,
	input  wire  [1:0]                          gain_range,
	input  wire  signed [mcsc_pkg::CHARGE_W-1:0] charge,
	input  wire                                 hit_zero,
	input  wire                                 hit_one,
	input  wire                                 hit_two,
	input  wire  signed [mcsc_pkg::TD_W-1:0]     time_diff_zero,
	input  wire  signed [mcsc_pkg::TD_W-1:0]     time_diff_one,
	input  wire  signed [mcsc_pkg::TD_W-1:0]     time_diff_two,
	output mcsc_pkg::nbr_t                      nbr_lo_s1,
	output mcsc_pkg::nbr_t                      nbr_hi_s1,
	output logic signed [mcsc_pkg::CHARGE_W-1:0] charge_s1
);

	function automatic mcsc_pkg::nbr_t make_nbr(
		input logic                              hit,
		input logic signed [mcsc_pkg::TD_W-1:0]  td,
		input logic                              cfg_ok,
		input logic [mcsc_pkg::COEF_IDX_W-1:0]   idx
	);
		logic signed [mcsc_pkg::NUM_W-1:0] num;
		logic [mcsc_pkg::NUM_C_W-1:0]      num_c;
		logic [mcsc_pkg::BINQ_W-1:0]       q;
		mcsc_pkg::nbr_t                    r;
		num      = mcsc_pkg::NUM_W'(td) + mcsc_pkg::NUM_OFFSET;
		num_c    = num[mcsc_pkg::NUM_W-1] ? '0 : num[mcsc_pkg::NUM_C_W-1:0];
		q        = mcsc_pkg::BINQ_W'(num_c) * mcsc_pkg::BINQ_W'(mcsc_pkg::RECIP);
		r.en     = cfg_ok & hit;
		r.bin_ok = (num > mcsc_pkg::NUM_LOW) && (num < mcsc_pkg::NUM_HIGH);
		r.bin    = q[mcsc_pkg::RECIP_SHIFT +: mcsc_pkg::BIN_W];
		r.a      = mcsc_pkg::COEF_A[idx];
		r.b      = mcsc_pkg::COEF_B[idx];
		return r;
	endfunction

	logic                               cfg_ok;
	logic [mcsc_pkg::COEF_IDX_W-1:0]    idx_lo;
	logic [mcsc_pkg::COEF_IDX_W-1:0]    idx_hi;
	logic                               hit_lo;
	logic                               hit_hi;
	logic signed [mcsc_pkg::TD_W-1:0]   td_lo;
	logic signed [mcsc_pkg::TD_W-1:0]   td_hi;

	always_comb begin
		cfg_ok = (main_channel != mcsc_pkg::CH_NONE) && (gain_range != mcsc_pkg::RANGE_NONE);
		idx_lo = '0;
		if (cfg_ok) begin
			idx_lo = mcsc_pkg::COEF_IDX_W'(main_channel) *
				mcsc_pkg::COEF_IDX_W'(mcsc_pkg::NBR_COUNT * mcsc_pkg::RANGE_COUNT) +
				mcsc_pkg::COEF_IDX_W'(gain_range);
		end
		idx_hi = idx_lo + mcsc_pkg::COEF_IDX_W'(mcsc_pkg::RANGE_COUNT);
		// lower neighbour is channel zero unless main is channel zero
		hit_lo = (main_channel == mcsc_pkg::CH_ZERO) ? hit_one : hit_zero;
		td_lo  = (main_channel == mcsc_pkg::CH_ZERO) ? time_diff_one : time_diff_zero;
		// higher neighbour is channel two unless main is channel two
		hit_hi = (main_channel == mcsc_pkg::CH_TWO) ? hit_one : hit_two;
		td_hi  = (main_channel == mcsc_pkg::CH_TWO) ? time_diff_one : time_diff_two;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			nbr_lo_s1 <= make_nbr(hit_lo, td_lo, cfg_ok, idx_lo);
			nbr_hi_s1 <= make_nbr(hit_hi, td_hi, cfg_ok, idx_hi);
			charge_s1 <= charge;
		end
	end

endmodule

`default_nettype wire

@@ src/mcsc_term.sv @@
// mcsc_term: stages 2 and 3 for one neighbour, linear drift and delay factor, then their product
// uses mcsc_pkg
`default_nettype none

module mcsc_term (
	input  wire                                  clk,
	input  mcsc_pkg::stage_en_t                  en,
	input  mcsc_pkg::nbr_t                       nbr_s1,
	input  wire  signed [mcsc_pkg::CHARGE_W-1:0] charge_s1,
	output logic signed [mcsc_pkg::PROD_W-1:0]   prod_s3
);

	logic signed [mcsc_pkg::BC_W-1:0]    bc;
	logic signed [mcsc_pkg::DRIFT_W-1:0] drift_s2;
	logic signed [mcsc_pkg::FACT_W-1:0]  fact_s2;

	assign bc = $signed(nbr_s1.b) * charge_s1;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			drift_s2 <= (mcsc_pkg::DRIFT_W'($signed(nbr_s1.a)) <<< 4) +
				mcsc_pkg::DRIFT_W'(bc);
			// no hit, invalid channel or range, or bin out of table gives zero weight
			fact_s2 <= (nbr_s1.en && nbr_s1.bin_ok) ? mcsc_pkg::FACT[nbr_s1.bin] : '0;
		end
		if (en.s3) begin
			prod_s3 <= mcsc_pkg::PROD_W'(drift_s2) * mcsc_pkg::PROD_W'(fact_s2);
		end
	end

endmodule

`default_nettype wire

@@ src/mcsc_sum.sv @@
// mcsc_sum: stages 4 and 5, sums both neighbour terms, truncates toward zero and saturates
// uses mcsc_pkg
`default_nettype none

module mcsc_sum (
	input  wire                                clk,
	input  mcsc_pkg::stage_en_t                en,
	input  wire  signed [mcsc_pkg::PROD_W-1:0] prod_lo_s3,
	input  wire  signed [mcsc_pkg::PROD_W-1:0] prod_hi_s3,
	output logic signed [mcsc_pkg::SHIFT_W-1:0] shift_s5
);

	logic signed [mcsc_pkg::SUM_W-1:0]   sum_s4;
	logic signed [mcsc_pkg::SUM_W-1:0]   biased;
	logic signed [mcsc_pkg::QUO_W-1:0]   quo;
	logic signed [mcsc_pkg::SHIFT_W-1:0] shift_d;

	always_comb begin
		// negative sums get a bias so the shift truncates toward zero
		biased = sum_s4 + (sum_s4[mcsc_pkg::SUM_W-1] ? mcsc_pkg::TRUNC_BIAS : '0);
		quo    = biased[mcsc_pkg::SUM_W-1:mcsc_pkg::FRAC_SHIFT];
		if (quo > mcsc_pkg::QUO_W'(mcsc_pkg::OUT_MAX)) begin
			shift_d = mcsc_pkg::OUT_MAX;
		end else if (quo < mcsc_pkg::QUO_W'(mcsc_pkg::OUT_MIN)) begin
			shift_d = mcsc_pkg::OUT_MIN;
		end else begin
			shift_d = quo[mcsc_pkg::SHIFT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			sum_s4 <= mcsc_pkg::SUM_W'(prod_lo_s3) + mcsc_pkg::SUM_W'(prod_hi_s3);
		end
		if (en.s5) begin
			shift_s5 <= shift_d;
		end
	end

endmodule

`default_nettype wire

@@ src/multihit_charge_shift_correction.sv @@
// multihit_charge_shift_correction: top level, stream ports and stage handshake
// instantiates mcsc_front, two mcsc_term and mcsc_sum; uses mcsc_pkg
//
// Crosstalk charge shift for a three-channel charge-to-time converter. Each request carries
// the main channel and gain range in s_tuser and the charge, hit flags and time differences
// in s_tdata; one result per request comes out on m_tdata as a signed shift in 1/256 counts.
// The block is a five stage pipeline that takes a request every cycle unless all stages are
// full and m_tready is low; results pass s1 to s5 in turn. Each stage holds its item while the
// stage after it is full and stalled, so s_tready stays high while a bubble is left anywhere
// in the pipeline. The deepest stage is the multiply of the linear drift by the delay factor.
`default_nettype none

module multihit_charge_shift_correction (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// charge[16:0], hit_zero[17], hit_one[18], hit_two[19], time_diff_zero[35:20],
	// time_diff_one[51:36], time_diff_two[67:52], zero[71:68]
	input  wire  [mcsc_pkg::S_TDATA_W-1:0]    s_tdata,
	// main_channel[1:0], gain_range[3:2]
	input  wire  [mcsc_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// charge_shift[19:0], zero[23:20]
	output logic [mcsc_pkg::M_TDATA_W-1:0]    m_tdata
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	mcsc_pkg::stage_en_t en;

	mcsc_pkg::nbr_t                       nbr_lo_s1;
	mcsc_pkg::nbr_t                       nbr_hi_s1;
	logic signed [mcsc_pkg::CHARGE_W-1:0] charge_s1;
	logic signed [mcsc_pkg::PROD_W-1:0]   prod_lo_s3;
	logic signed [mcsc_pkg::PROD_W-1:0]   prod_hi_s3;
	logic signed [mcsc_pkg::SHIFT_W-1:0]  shift_s5;

	assign rdy5 = !v_s5 || m_tready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4, s5: rdy5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	mcsc_front u_front (
		.clk            (clk),
		.en             (en),
		.main_channel   (s_tuser[1:0]),
		.gain_range     (s_tuser[3:2]),
		.charge         ($signed(s_tdata[16:0])),
		.hit_zero       (s_tdata[17]),
		.hit_one        (s_tdata[18]),
		.hit_two        (s_tdata[19]),
		.time_diff_zero ($signed(s_tdata[35:20])),
		.time_diff_one  ($signed(s_tdata[51:36])),
		.time_diff_two  ($signed(s_tdata[67:52])),
		.nbr_lo_s1      (nbr_lo_s1),
		.nbr_hi_s1      (nbr_hi_s1),
		.charge_s1      (charge_s1)
	);

	mcsc_term u_term_lo (
		.clk       (clk),
		.en        (en),
		.nbr_s1    (nbr_lo_s1),
		.charge_s1 (charge_s1),
		.prod_s3   (prod_lo_s3)
	);

	mcsc_term u_term_hi (
		.clk       (clk),
		.en        (en),
		.nbr_s1    (nbr_hi_s1),
		.charge_s1 (charge_s1),
		.prod_s3   (prod_hi_s3)
	);

	mcsc_sum u_sum (
		.clk        (clk),
		.en         (en),
		.prod_lo_s3 (prod_lo_s3),
		.prod_hi_s3 (prod_hi_s3),
		.shift_s5   (shift_s5)
	);

	assign s_tready = rdy1;
	assign m_tvalid = v_s5;
	assign m_tdata  = {{(mcsc_pkg::M_TDATA_W - mcsc_pkg::SHIFT_W){1'b0}}, shift_s5};

endmodule

`default_nettype wire

@@ src/mcsc_checker.sv @@
// mcsc_checker: port-level checks on the charge shift correction, bound to the top level
// uses mcsc_pkg for port widths
`default_nettype none

module mcsc_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_tvalid,
	input wire                            s_tready,
	input wire [mcsc_pkg::S_TDATA_W-1:0]  s_tdata,
	input wire [mcsc_pkg::S_TUSER_W-1:0]  s_tuser,
	input wire                            m_tvalid,
	input wire                            m_tready,
	input wire [mcsc_pkg::M_TDATA_W-1:0]  m_tdata
);

	logic zero_req;

	assign zero_req = (s_tuser[1:0] == mcsc_pkg::CH_NONE) ||
		(s_tuser[3:2] == mcsc_pkg::RANGE_NONE) ||
		(!s_tdata[17] && !s_tdata[18] && !s_tdata[19]);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// an empty or draining output stage never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input blocked while output can move");

	// with m_tready held high, an accepted request reaches m_tvalid through stages s1 to s5
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
		|=> m_tvalid)
		else $error("result missing after pipeline latency");

	// invalid channel, invalid range or no hit gives a zero shift
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && zero_req ##1 m_tready ##1 m_tready ##1 m_tready
		##1 m_tready |=> m_tvalid && (m_tdata[mcsc_pkg::SHIFT_W-1:0] == '0))
		else $error("nonzero shift for a request without drift");

endmodule

bind multihit_charge_shift_correction mcsc_checker u_mcsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
